>>> design/mfbp_pkg.sv
package mfbp_pkg;

    // payload widths of the channels
    localparam int FIELD_W = 16;
    localparam int WIDTH_W = 5;
    localparam int BYTE_W  = 8;

    // default field width limit and front/back queue depth
    localparam int MAX_FIELD_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH         = 2;

    // item codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

    // classified item handed from front to back
    typedef struct packed {
        logic               flush;
        logic [FIELD_W-1:0] bits;   // already masked to width
        logic [WIDTH_W-1:0] width;  // already saturated
    } t_item;

endpackage

>>> design/mfbp_if.sv
interface mfbp_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [mfbp_pkg::FIELD_W-1:0] field_bits;
    logic [mfbp_pkg::WIDTH_W-1:0] field_width;

    modport source (output valid, mode, field_bits, field_width, input ready);
    modport sink   (input valid, mode, field_bits, field_width, output ready);
endinterface

interface mfbp_out_if;
    logic                        valid;
    logic                        ready;
    logic [mfbp_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

>>> design/mfbp_front.sv
module mfbp_front #(
    parameter int MAX_FIELD_WIDTH = mfbp_pkg::MAX_FIELD_WIDTH_DEF
) (
    mfbp_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output mfbp_pkg::t_item o_item
);

    localparam logic [mfbp_pkg::WIDTH_W:0] MAX_WX = (mfbp_pkg::WIDTH_W+1)'(MAX_FIELD_WIDTH);

    logic                         sat;
    logic [mfbp_pkg::WIDTH_W-1:0] eff_w;
    logic [mfbp_pkg::FIELD_W-1:0] mask;

    always_comb begin
        sat   = {1'b0, i_in.field_width} > MAX_WX;
        eff_w = sat ? MAX_WX[mfbp_pkg::WIDTH_W-1:0] : i_in.field_width;
        // shift of 16 or more clears the whole field -> full mask
        mask  = ~({mfbp_pkg::FIELD_W{1'b1}} << eff_w);
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        if (i_in.mode == mfbp_pkg::MODE_FLUSH) begin
            o_item.flush = 1'b1;
            o_item.bits  = '0;
            o_item.width = '0;
        end else begin
            o_item.flush = 1'b0;
            o_item.bits  = i_in.field_bits & mask;
            o_item.width = eff_w;
        end
    end

endmodule

>>> design/mfbp_queue.sv
module mfbp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mfbp_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mfbp_pkg::t_item o_head
);

    localparam int DEPTH = mfbp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfbp_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

>>> design/mfbp_back.sv
module mfbp_back #(
    parameter int MAX_FIELD_WIDTH = mfbp_pkg::MAX_FIELD_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  mfbp_pkg::t_item i_head,
    output logic            o_pop,
    mfbp_out_if.source      o_out
);

    localparam int BW    = mfbp_pkg::BYTE_W;
    localparam int ACC_W = BW + MAX_FIELD_WIDTH;
    localparam int EXT_W = (ACC_W > mfbp_pkg::FIELD_W) ? ACC_W : mfbp_pkg::FIELD_W;
    localparam int CNT_W = $clog2(ACC_W + 1);

    // bits gathered, left aligned; bits below the top r_cnt are always zero
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic          r_out_valid, n_out_valid;
    logic [BW-1:0] r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    logic             emitting;
    logic             slot_free;
    logic [EXT_W-1:0] fld_ext;
    logic [ACC_W-1:0] fld;
    logic [CNT_W-1:0] sh;
    logic [CNT_W-1:0] cnt_after;

    assign emitting  = (r_cnt >= CNT_W'(BW));
    assign slot_free = !r_out_valid || o_out.ready;
    assign o_pop     = !emitting && !i_empty;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    always_comb begin
        fld_ext   = EXT_W'(i_head.bits);
        fld       = fld_ext[ACC_W-1:0];
        sh        = CNT_W'(ACC_W) - r_cnt - CNT_W'(i_head.width);
        cnt_after = r_cnt - CNT_W'(BW);

        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (emitting) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_out_byte  = r_acc[ACC_W-1 -: BW];
                n_out_last  = (cnt_after < CNT_W'(BW));
                n_acc       = r_acc << BW;
                n_cnt       = cnt_after;
            end
        end else if (!i_empty) begin
            if (i_head.flush) begin
                // pad with ones up to a whole byte; nothing to send when empty
                if (r_cnt != '0) begin
                    n_acc = r_acc | {mfbp_pkg::PAD_BYTE >> r_cnt[2:0],
                                     {MAX_FIELD_WIDTH{1'b0}}};
                    n_cnt = CNT_W'(BW);
                end
            end else begin
                n_acc = r_acc | (fld << sh);
                n_cnt = r_cnt + CNT_W'(i_head.width);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

endmodule

>>> design/msb_first_bit_packer.sv
// MSB-first bit packer. Each input beat either appends the low
// field_width bits of field_bits (most significant bit first, width
// saturated at MAX_FIELD_WIDTH) or flushes the pending partial byte padded
// with ones. Completed bytes leave one per output beat, first bit in bit 7,
// with last set on the final byte an input beat caused; a write of zero
// width or a flush with nothing pending sends nothing. Flow: the front
// takes a beat whenever its two-entry queue has room; the back loads an
// item into its bit accumulator and then sends each completed byte through
// the single output register, which the receiver can stall, and pops the
// next item only once fewer than eight bits are pending.
module msb_first_bit_packer #(
    parameter int MAX_FIELD_WIDTH = mfbp_pkg::MAX_FIELD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfbp_in_if.sink     i_in,
    mfbp_out_if.source  o_out
);

    // front -> queue
    logic            push;
    logic            full;
    mfbp_pkg::t_item item;

    // queue -> back
    logic            pop;
    logic            empty;
    mfbp_pkg::t_item head;

    // Front: saturates the width, masks the field, classifies write/flush.
    mfbp_front #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (item)
    );

    // Short queue so the input side keeps flowing while bytes drain.
    mfbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Back: bit accumulator plus output register; one byte per beat.
    mfbp_back #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> verif/tb_msb_first_bit_packer.sv
module tb_msb_first_bit_packer;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Clock, reset and the two channels
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mfbp_in_if  in_ch ();
    mfbp_out_if out_ch ();

    msb_first_bit_packer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // ------------------------------------------------------------------
    // Directed table. A row either carries its bytes typed in (n_exp of
    // 0..2, last implied on the final one) or defers to the packer model.
    // ------------------------------------------------------------------
    localparam int BY_MODEL   = -1;
    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM   = 1300;
    localparam int CALM_TAIL  = 300;   // last beats run without idling
    localparam int HOLD_AT    = 500;   // sender waits for a drained stream here

    typedef struct packed {
        logic                         mode;
        logic [mfbp_pkg::FIELD_W-1:0] bits;
        logic [mfbp_pkg::WIDTH_W-1:0] width;
        int                           n_exp;
        logic [mfbp_pkg::BYTE_W-1:0]  exp0;
        logic [mfbp_pkg::BYTE_W-1:0]  exp1;
    } t_row;

    t_row dir_rows [0:N_DIRECTED-1] = '{
        // widest patterns and the plain byte from an empty packer
        '{mfbp_pkg::MODE_WRITE, 16'h00A5, 5'd8,  1,        8'hA5, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'hFFFF, 5'd16, 2,        8'hFF, 8'hFF},
        '{mfbp_pkg::MODE_WRITE, 16'h0000, 5'd16, 2,        8'h00, 8'h00},
        // flush with nothing pending, junk fields ignored
        '{mfbp_pkg::MODE_FLUSH, 16'hFFFF, 5'd31, 0,        8'h00, 8'h00},
        // zero width appends nothing
        '{mfbp_pkg::MODE_WRITE, 16'hFFFF, 5'd0,  0,        8'h00, 8'h00},
        // single bit then flush: padding fills the rest with ones
        '{mfbp_pkg::MODE_WRITE, 16'h0001, 5'd1,  BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_FLUSH, 16'h0000, 5'd0,  1,        8'hFF, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'h0000, 5'd1,  BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_FLUSH, 16'h0000, 5'd0,  1,        8'h7F, 8'h00},
        // widths past the limit saturate to 16
        '{mfbp_pkg::MODE_WRITE, 16'h1234, 5'd31, 2,        8'h12, 8'h34},
        '{mfbp_pkg::MODE_WRITE, 16'hFFFF, 5'd17, 2,        8'hFF, 8'hFF},
        // unaligned runs crossing byte borders
        '{mfbp_pkg::MODE_WRITE, 16'h0005, 5'd3,  BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'hABCD, 5'd16, BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'h0003, 5'd4,  BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_FLUSH, 16'hFFFF, 5'd16, BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'h007F, 5'd7,  BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'h0001, 5'd1,  BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'hFFFF, 5'd9,  BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'h0000, 5'd15, BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_FLUSH, 16'h0000, 5'd0,  BY_MODEL, 8'h00, 8'h00},
        // lone top bit and lone bottom bit of a full field
        '{mfbp_pkg::MODE_WRITE, 16'h8000, 5'd16, 2,        8'h80, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'h0001, 5'd16, 2,        8'h00, 8'h01},
        // leave seven bits pending, then a full field on top of them
        '{mfbp_pkg::MODE_WRITE, 16'hFFFE, 5'd7,  BY_MODEL, 8'h00, 8'h00},
        '{mfbp_pkg::MODE_WRITE, 16'h0000, 5'd16, BY_MODEL, 8'h00, 8'h00}
    };

    // ------------------------------------------------------------------
    // Packer model: its own copy of the partial byte and the fill count,
    // plus the ordered store of bytes still owed by the block.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [mfbp_pkg::BYTE_W-1:0] data;
        logic                        last;
    } t_due;

    logic [mfbp_pkg::BYTE_W-1:0] acc_byte;
    int                          acc_cnt;
    t_due                        due_bytes [$];

    int err_cnt   = 0;
    int beat_cnt  = 0;
    int flush_cnt = 0;
    int sat_cnt   = 0;
    int zero_cnt  = 0;
    int byte_cnt  = 0;

    int row_tag;          // directed row of the beat on the bus, -1 for random
    bit idle_on = 1'b1;

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Appends one accepted beat to the model and returns how many bytes it owes.
    function automatic int pack_field(input logic mode,
                                      input logic [mfbp_pkg::FIELD_W-1:0] bits,
                                      input logic [mfbp_pkg::WIDTH_W-1:0] width);
        int   n;
        int   k;
        int   first;
        t_due tail;
        first = due_bytes.size();
        if (mode == mfbp_pkg::MODE_FLUSH) begin
            if (acc_cnt != 0)
                due_bytes.push_back('{acc_byte | (mfbp_pkg::PAD_BYTE >> acc_cnt), 1'b0});
            acc_byte = '0;
            acc_cnt  = 0;
        end else begin
            n = (int'(width) > mfbp_pkg::MAX_FIELD_WIDTH_DEF) ?
                mfbp_pkg::MAX_FIELD_WIDTH_DEF : int'(width);
            for (k = n - 1; k >= 0; k--) begin
                if (bits[k])
                    acc_byte[7 - acc_cnt] = 1'b1;
                acc_cnt++;
                if (acc_cnt == 8) begin
                    due_bytes.push_back('{acc_byte, 1'b0});
                    acc_byte = '0;
                    acc_cnt  = 0;
                end
            end
        end
        if (due_bytes.size() > first) begin
            tail = due_bytes[due_bytes.size() - 1];
            tail.last = 1'b1;
            due_bytes[due_bytes.size() - 1] = tail;
        end
        return due_bytes.size() - first;
    endfunction

    // Input beat accepted: run the model; a typed-in row replaces its bytes.
    task automatic log_in_beat();
        int   n;
        t_row r;
        n = pack_field(in_ch.mode, in_ch.field_bits, in_ch.field_width);
        beat_cnt++;
        if (in_ch.mode == mfbp_pkg::MODE_FLUSH)
            flush_cnt++;
        else if (in_ch.field_width > 5'(mfbp_pkg::MAX_FIELD_WIDTH_DEF))
            sat_cnt++;
        else if (in_ch.field_width == '0)
            zero_cnt++;
        if (row_tag >= 0 && dir_rows[row_tag].n_exp != BY_MODEL) begin
            r = dir_rows[row_tag];
            repeat (n) void'(due_bytes.pop_back());
            if (r.n_exp == 1)
                due_bytes.push_back('{r.exp0, 1'b1});
            if (r.n_exp == 2) begin
                due_bytes.push_back('{r.exp0, 1'b0});
                due_bytes.push_back('{r.exp1, 1'b1});
            end
        end
    endtask

    // Output beat accepted: compare against the oldest owed byte.
    task automatic check_out_beat();
        t_due want;
        byte_cnt++;
        if (due_bytes.size() == 0) begin
            report_err($sformatf("byte %02h last=%0b with nothing owed",
                                 out_ch.out_byte, out_ch.last));
        end else begin
            want = due_bytes.pop_front();
            if (out_ch.out_byte !== want.data)
                report_err($sformatf("out_byte %02h, want %02h", out_ch.out_byte, want.data));
            if (out_ch.last !== want.last)
                report_err($sformatf("last %0b on byte %02h, want %0b",
                                     out_ch.last, want.data, want.last));
        end
    endtask

    // Both channels are sampled at the edge, before any of this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                check_out_beat();
            if (in_ch.valid && in_ch.ready)
                log_in_beat();
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready drops in random bursts while idling is on.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 4);
        out_ch.ready <= (stall_left == 0);
        if (stall_left != 0)
            stall_left--;
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_beat(input logic mode, input logic [mfbp_pkg::FIELD_W-1:0] bits,
                             input logic [mfbp_pkg::WIDTH_W-1:0] width, input int tag);
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.field_bits  <= bits;
        in_ch.field_width <= width;
        row_tag           <= tag;
        do @(posedge i_clk); while (!in_ch.ready);
        // random gap after the beat; valid stays up otherwise
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every owed byte has left.
    task automatic drain_stream();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (due_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic                         mode;
        logic [mfbp_pkg::FIELD_W-1:0] bits;
        logic [mfbp_pkg::WIDTH_W-1:0] width;
        int                           pick;

        acc_byte = '0;
        acc_cnt  = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= mfbp_pkg::MODE_WRITE;
        in_ch.field_bits  <= '0;
        in_ch.field_width <= '0;
        row_tag           <= -1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_beat(dir_rows[i].mode, dir_rows[i].bits, dir_rows[i].width, i);

        // Random beats: mostly in-range writes, with flushes, zero widths and
        // over-limit widths mixed in. Field bits are fully random.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == HOLD_AT)
                drain_stream();
            if (i == N_RANDOM - CALM_TAIL)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            bits = mfbp_pkg::FIELD_W'($urandom);
            mode = mfbp_pkg::MODE_WRITE;
            if (pick < 15) begin
                mode  = mfbp_pkg::MODE_FLUSH;
                width = mfbp_pkg::WIDTH_W'($urandom_range(0, 31));
            end else if (pick < 22) begin
                width = mfbp_pkg::WIDTH_W'($urandom_range(17, 31));
            end else if (pick < 26) begin
                width = '0;
            end else begin
                width = mfbp_pkg::WIDTH_W'($urandom_range(1, 16));
            end
            send_beat(mode, bits, width, -1);
        end

        // Everything sent: wait out the owed bytes, then a tail for strays.
        drain_stream();
        repeat (20) @(posedge i_clk);
        if (due_bytes.size() != 0)
            report_err($sformatf("%0d bytes never arrived", due_bytes.size()));

        $display("Sent %0d beats: %0d flushes, %0d zero-width, %0d over-limit widths.",
                 beat_cnt, flush_cnt, zero_cnt, sat_cnt);
        $display("Compared %0d output bytes, %0d mismatches.", byte_cnt, err_cnt);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule
